// ===== hw/rtl/angular_moment_trapezoid_assert.svh =====
// Assertion macros for the angular moment block; they use the enclosing clk and rst_n.
`ifndef ANGULAR_MOMENT_TRAPEZOID_ASSERT_SVH
`define ANGULAR_MOMENT_TRAPEZOID_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define AMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("angular moment assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define AMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("angular moment assertion failed");

`endif

// ===== hw/rtl/amt_pkg.sv =====
// Shared types and constants for the angular moment block.
package amt_pkg;

  localparam int WL_W    = 10;
  localparam int MU_W    = 16;
  localparam int INT_W   = 24;
  localparam int MOM_W   = 48;
  localparam int FRAC_W  = 15;
  localparam int SUM_W   = 50;
  localparam int ACC_W   = SUM_W + 2;
  localparam int A_W     = 44;
  localparam int B_W     = 18;
  localparam int P_W     = A_W + B_W;
  localparam int TERM_W  = P_W - FRAC_W;

  localparam logic signed [P_W-1:0] RND_HALF =
    {{(P_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_MI,
    ST_M2I,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_FIN,
    ST_EMIT
  } amt_state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_MI,
    MUL_M2I,
    MUL_T0,
    MUL_T1,
    MUL_T2
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_J,
    ACC_H,
    ACC_K
  } acc_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_op_t  op;
    logic     ld_m2;
    logic     ld_mi;
    logic     ld_m2i;
    acc_sel_t acc;
    logic     commit;
    logic     emit;
  } amt_cmd_t;

  typedef struct packed {
    logic last;
    logic have_prev;
  } amt_sts_t;

endpackage

// ===== hw/rtl/amt_ctrl.sv =====
// Sequencer for the angular moment block: steps the shared multiplier and the handshakes.
module amt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  amt_pkg::amt_sts_t sts,
  output amt_pkg::amt_cmd_t cmd
);

  amt_pkg::amt_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= amt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.op      = amt_pkg::MUL_NONE;
    cmd.acc     = amt_pkg::ACC_NONE;
    case (state_r)
      amt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = amt_pkg::ST_SQ;
        end
      end
      amt_pkg::ST_SQ: begin
        cmd.op    = amt_pkg::MUL_SQ;
        state_nxt = amt_pkg::ST_MI;
      end
      amt_pkg::ST_MI: begin
        cmd.op    = amt_pkg::MUL_MI;
        cmd.ld_m2 = 1'b1;
        state_nxt = amt_pkg::ST_M2I;
      end
      amt_pkg::ST_M2I: begin
        cmd.op    = amt_pkg::MUL_M2I;
        cmd.ld_mi = 1'b1;
        state_nxt = amt_pkg::ST_T0;
      end
      amt_pkg::ST_T0: begin
        cmd.op     = amt_pkg::MUL_T0;
        cmd.ld_m2i = 1'b1;
        state_nxt  = amt_pkg::ST_T1;
      end
      amt_pkg::ST_T1: begin
        cmd.op    = amt_pkg::MUL_T1;
        cmd.acc   = sts.have_prev ? amt_pkg::ACC_J : amt_pkg::ACC_NONE;
        state_nxt = amt_pkg::ST_T2;
      end
      amt_pkg::ST_T2: begin
        cmd.op    = amt_pkg::MUL_T2;
        cmd.acc   = sts.have_prev ? amt_pkg::ACC_H : amt_pkg::ACC_NONE;
        state_nxt = amt_pkg::ST_FIN;
      end
      amt_pkg::ST_FIN: begin
        cmd.acc    = sts.have_prev ? amt_pkg::ACC_K : amt_pkg::ACC_NONE;
        cmd.commit = 1'b1;
        state_nxt  = sts.last ? amt_pkg::ST_EMIT : amt_pkg::ST_IDLE;
      end
      amt_pkg::ST_EMIT: begin
        // The result register must be empty or emptying before it is reloaded.
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = amt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = amt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/amt_dp.sv =====
// Datapath for the angular moment block: shared multiplier, trapezoid sums and result register.
module amt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  amt_pkg::amt_cmd_t                   cmd,
  output amt_pkg::amt_sts_t                   sts,
  input  logic        [amt_pkg::WL_W-1:0]     in_wavelength_index,
  input  logic signed [amt_pkg::MU_W-1:0]     in_direction_cosine,
  input  logic        [amt_pkg::INT_W-1:0]    in_intensity,
  input  logic                                in_last_ray,
  output logic        [amt_pkg::WL_W-1:0]     out_wavelength_out,
  output logic signed [amt_pkg::MOM_W-1:0]    out_moment_j,
  output logic signed [amt_pkg::MOM_W-1:0]    out_moment_h,
  output logic signed [amt_pkg::MOM_W-1:0]    out_moment_k,
  output logic                                out_overflow
);

  localparam int A_W    = amt_pkg::A_W;
  localparam int B_W    = amt_pkg::B_W;
  localparam int P_W    = amt_pkg::P_W;
  localparam int MU_W   = amt_pkg::MU_W;
  localparam int INT_W  = amt_pkg::INT_W;
  localparam int SUM_W  = amt_pkg::SUM_W;
  localparam int ACC_W  = amt_pkg::ACC_W;
  localparam int TERM_W = amt_pkg::TERM_W;

  // Current sample.
  logic        [amt_pkg::WL_W-1:0] cur_wl_r;
  logic signed [MU_W-1:0]          cur_mu_r;
  logic        [INT_W-1:0]         cur_i_r;
  logic                            cur_last_r;

  // Previous sample and its products, kept so they are not formed twice.
  logic signed [MU_W-1:0]  prev_mu_r;
  logic        [INT_W-1:0] prev_i_r;
  logic signed [A_W-1:0]   prev_mi_r;
  logic signed [A_W-1:0]   prev_m2i_r;
  logic                    have_prev_r;

  logic signed [B_W-1:0] m2_r;
  logic signed [A_W-1:0] mi_r;
  logic signed [A_W-1:0] m2i_r;
  logic signed [P_W-1:0] prod_r, prod_nxt;

  logic signed [SUM_W-1:0] sum_j_r, sum_h_r, sum_k_r;
  logic                    sat_r;

  logic signed [A_W-1:0]    a_op;
  logic signed [B_W-1:0]    b_op;
  logic signed [B_W-1:0]    mu_step;
  logic signed [P_W-1:0]    rnd_full;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  sum_cur;
  logic signed [ACC_W-1:0]  acc_raw;
  logic signed [SUM_W-1:0]  acc_res;
  logic                     acc_clamp;

  assign mu_step = {{(B_W-MU_W){cur_mu_r[MU_W-1]}}, cur_mu_r}
                 - {{(B_W-MU_W){prev_mu_r[MU_W-1]}}, prev_mu_r};

  always_comb begin
    case (cmd.op)
      amt_pkg::MUL_SQ: begin
        a_op = {{(A_W-MU_W){cur_mu_r[MU_W-1]}}, cur_mu_r};
        b_op = {{(B_W-MU_W){cur_mu_r[MU_W-1]}}, cur_mu_r};
      end
      amt_pkg::MUL_MI: begin
        a_op = {{(A_W-INT_W){1'b0}}, cur_i_r};
        b_op = {{(B_W-MU_W){cur_mu_r[MU_W-1]}}, cur_mu_r};
      end
      amt_pkg::MUL_M2I: begin
        a_op = {{(A_W-INT_W){1'b0}}, cur_i_r};
        b_op = m2_r;
      end
      amt_pkg::MUL_T0: begin
        a_op = {{(A_W-INT_W){1'b0}}, cur_i_r} + {{(A_W-INT_W){1'b0}}, prev_i_r};
        b_op = mu_step;
      end
      amt_pkg::MUL_T1: begin
        a_op = prev_mi_r + mi_r;
        b_op = mu_step;
      end
      amt_pkg::MUL_T2: begin
        a_op = prev_m2i_r + m2i_r;
        b_op = mu_step;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
    prod_nxt = a_op * b_op;
  end

  // Round half up at 2^-15; the arithmetic shift gives the floor.
  assign rnd_full = (prod_r + amt_pkg::RND_HALF) >>> amt_pkg::FRAC_W;

  always_comb begin
    term    = rnd_full[TERM_W-1:0];
    sum_cur = sum_k_r;
    case (cmd.acc)
      amt_pkg::ACC_J: begin
        term    = prod_r[TERM_W-1:0];
        sum_cur = sum_j_r;
      end
      amt_pkg::ACC_H: begin
        sum_cur = sum_h_r;
      end
      amt_pkg::ACC_K: begin
        sum_cur = sum_k_r;
      end
      default: begin
        sum_cur = sum_k_r;
      end
    endcase
    acc_raw = {{(ACC_W-SUM_W){sum_cur[SUM_W-1]}}, sum_cur}
            + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
    acc_clamp = 1'b0;
    acc_res   = acc_raw[SUM_W-1:0];
    // The result leaves the sum range when the top three bits disagree.
    if (!acc_raw[ACC_W-1] && (|acc_raw[ACC_W-2:SUM_W-1])) begin
      acc_clamp = 1'b1;
      acc_res   = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (acc_raw[ACC_W-1] && !(&acc_raw[ACC_W-2:SUM_W-1])) begin
      acc_clamp = 1'b1;
      acc_res   = {1'b1, {(SUM_W-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load_in) begin
      cur_wl_r   <= in_wavelength_index;
      cur_mu_r   <= in_direction_cosine;
      cur_i_r    <= in_intensity;
      cur_last_r <= in_last_ray;
    end
    if (cmd.ld_m2) begin
      m2_r <= rnd_full[B_W-1:0];
    end
    if (cmd.ld_mi) begin
      mi_r <= prod_r[A_W-1:0];
    end
    if (cmd.ld_m2i) begin
      m2i_r <= prod_r[A_W-1:0];
    end
    if (cmd.commit) begin
      prev_mu_r  <= cur_mu_r;
      prev_i_r   <= cur_i_r;
      prev_mi_r  <= mi_r;
      prev_m2i_r <= m2i_r;
    end
    if (cmd.emit) begin
      out_wavelength_out <= cur_wl_r;
      out_moment_j       <= sum_j_r[SUM_W-1:2];
      out_moment_h       <= sum_h_r[SUM_W-1:2];
      out_moment_k       <= sum_k_r[SUM_W-1:2];
      out_overflow       <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_j_r     <= '0;
      sum_h_r     <= '0;
      sum_k_r     <= '0;
      sat_r       <= 1'b0;
      have_prev_r <= 1'b0;
    end else if (cmd.emit) begin
      sum_j_r     <= '0;
      sum_h_r     <= '0;
      sum_k_r     <= '0;
      sat_r       <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        have_prev_r <= 1'b1;
      end
      if (cmd.acc != amt_pkg::ACC_NONE) begin
        sat_r <= sat_r | acc_clamp;
      end
      case (cmd.acc)
        amt_pkg::ACC_J: sum_j_r <= acc_res;
        amt_pkg::ACC_H: sum_h_r <= acc_res;
        amt_pkg::ACC_K: sum_k_r <= acc_res;
        default: begin
        end
      endcase
    end
  end

  assign sts.last      = cur_last_r;
  assign sts.have_prev = have_prev_r;

endmodule

// ===== hw/rtl/angular_moment_trapezoid.sv =====
// Top level of the trapezoidal angular moment block (J, H and K over a run of ray samples).
//
// Each ray sample is accepted in the idle state; then a single shared 44 by 18 bit
// multiplier forms mu squared, mu*I, mu^2*I and the three trapezoid step products in turn,
// followed by the saturating additions, before the next sample can be accepted. The final
// sample of a run then loads the result register, and waits there while an earlier
// result has not yet been taken; a new sample is accepted while a result is pending. Results
// are floor(sum / 4) of 50-bit saturating sums, in intensity units times 2^15, and the
// overflow bit reports any saturation during the run. A run of a single sample yields zeros.
module angular_moment_trapezoid (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [amt_pkg::WL_W-1:0]     in_wavelength_index,
  input  logic signed [amt_pkg::MU_W-1:0]     in_direction_cosine,
  input  logic        [amt_pkg::INT_W-1:0]    in_intensity,
  input  logic                                in_last_ray,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [amt_pkg::WL_W-1:0]     out_wavelength_out,
  output logic signed [amt_pkg::MOM_W-1:0]    out_moment_j,
  output logic signed [amt_pkg::MOM_W-1:0]    out_moment_h,
  output logic signed [amt_pkg::MOM_W-1:0]    out_moment_k,
  output logic                                out_overflow
);

`include "angular_moment_trapezoid_assert.svh"

  amt_pkg::amt_cmd_t cmd;
  amt_pkg::amt_sts_t sts;

  amt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  amt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_wavelength_index (in_wavelength_index),
    .in_direction_cosine (in_direction_cosine),
    .in_intensity        (in_intensity),
    .in_last_ray         (in_last_ray),
    .out_wavelength_out  (out_wavelength_out),
    .out_moment_j        (out_moment_j),
    .out_moment_h        (out_moment_h),
    .out_moment_k        (out_moment_k),
    .out_overflow        (out_overflow)
  );

  // A transaction on the input keeps the block busy for the following cycle.
  `AMT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // A new result appears only after the controller loaded the result register.
  `AMT_ASSERT_SAME(a_result_from_emit, $rose(out_valid), $past(cmd.emit))
  // Emitting a result starts the next run with no previous sample.
  `AMT_ASSERT_NEXT(a_emit_clears_run, cmd.emit, !sts.have_prev)

endmodule
